// ===== hw/rtl/grid_line_overlay_macros.svh =====
// assertion macros for the grid line overlay checker
`ifndef GRID_LINE_OVERLAY_MACROS_SVH
`define GRID_LINE_OVERLAY_MACROS_SVH

// same-cycle implication, off during reset
`define GLO_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define GLO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// behavior of the cycle after a reset cycle
`define GLO_ASSERT_RESET(label, cons, msg) \
    label: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/glo_pkg.sv =====
// shared types, constants and color functions of the grid line overlay
package glo_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef enum logic [2:0] {
        COLOR_NONE  = 3'd0,
        COLOR_BLACK = 3'd1,
        COLOR_WHITE = 3'd2,
        COLOR_GREEN = 3'd3,
        COLOR_BLUE  = 3'd4,
        COLOR_RED   = 3'd5,
        COLOR_RSVD6 = 3'd6,
        COLOR_RSVD7 = 3'd7
    } color_code_t;

    typedef struct packed {
        logic [3:0]  thick;
        color_code_t color;
        logic        v_en;
        logic        h_en;
    } draw_style_t;

    localparam int STYLE_W = $bits(draw_style_t);
    localparam draw_style_t STYLE_RESET = draw_style_t'(9'd39);

    typedef enum logic [2:0] {
        REG_DRAW_STYLE = 3'd0,
        REG_FRAME_SIZE = 3'd1,
        REG_H_ORIGIN   = 3'd2,
        REG_H_GRID     = 3'd3,
        REG_H_SPAN     = 3'd4,
        REG_V_ORIGIN   = 3'd5,
        REG_V_GRID     = 3'd6,
        REG_V_SPAN     = 3'd7
    } cfg_reg_t;

    localparam rgb_t RGB_BLACK = '{red: 8'h00, green: 8'h00, blue: 8'h00};
    localparam rgb_t RGB_WHITE = '{red: 8'hff, green: 8'hff, blue: 8'hff};
    localparam rgb_t RGB_GREEN = '{red: 8'h00, green: 8'hff, blue: 8'h00};
    localparam rgb_t RGB_BLUE  = '{red: 8'h00, green: 8'h00, blue: 8'hff};
    localparam rgb_t RGB_RED   = '{red: 8'hff, green: 8'h00, blue: 8'h00};

    function automatic rgb_t color_of(input color_code_t code);
        rgb_t c;
        case (code)
            COLOR_WHITE: c = RGB_WHITE;
            COLOR_GREEN: c = RGB_GREEN;
            COLOR_BLUE:  c = RGB_BLUE;
            COLOR_RED:   c = RGB_RED;
            default:     c = RGB_BLACK;
        endcase
        return c;
    endfunction

    function automatic logic color_ok(input color_code_t code);
        logic ok;
        case (code)
            COLOR_BLACK, COLOR_WHITE, COLOR_GREEN, COLOR_BLUE, COLOR_RED: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ===== hw/rtl/glo_div.sv =====
// two-lane pipelined restoring divider, one quotient bit per stage
module glo_div #(
    parameter int DVD_W  = 15,
    parameter int DVS_W  = 14,
    parameter int SIDE_W = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [1:0][DVD_W-1:0]         in_dvd,
    input  logic [1:0][DVS_W-1:0]         dvs,
    input  logic [SIDE_W-1:0]             in_side,
    output logic                          out_valid,
    output logic [1:0][DVD_W-1:0]         out_quo,
    output logic [1:0][DVS_W-1:0]         out_rem,
    output logic [SIDE_W-1:0]             out_side
);

    logic                  vld_reg  [DVD_W];
    logic [1:0][DVD_W-1:0] qd_reg   [DVD_W];
    logic [1:0][DVS_W-1:0] rem_reg  [DVD_W];
    logic [SIDE_W-1:0]     side_reg [DVD_W];

    for (genvar j = 0; j < DVD_W; j++) begin : g_step
        logic                  vld_in;
        logic [1:0][DVD_W-1:0] qd_in;
        logic [1:0][DVS_W-1:0] rem_in;
        logic [SIDE_W-1:0]     side_in;
        logic [1:0][DVD_W-1:0] qd_next;
        logic [1:0][DVS_W-1:0] rem_next;

        if (j == 0) begin : g_first
            assign vld_in  = in_valid;
            assign qd_in   = in_dvd;
            assign rem_in  = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign vld_in  = vld_reg[j-1];
            assign qd_in   = qd_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DVS_W:0] trial;
            logic [DVS_W:0] diff;
            logic           ge;

            assign trial       = {rem_in[l], qd_in[l][DVD_W-1]};
            assign diff        = trial - {1'b0, dvs[l]};
            assign ge          = trial >= {1'b0, dvs[l]};
            assign rem_next[l] = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            assign qd_next[l]  = {qd_in[l][DVD_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                qd_reg[j]   <= qd_next;
                rem_reg[j]  <= rem_next;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[DVD_W-1];
    assign out_quo   = qd_reg[DVD_W-1];
    assign out_rem   = rem_reg[DVD_W-1];
    assign out_side  = side_reg[DVD_W-1];

endmodule

// ===== hw/rtl/grid_line_overlay.sv =====
// grid line overlay top level: config registers, pixel pipeline, output register
// throughput: one pixel per cycle; the pipeline halts only while a result waits and m_tready is low
// depth is set by the line-index divider, one quotient bit per stage per direction
// reset: synchronous active-low aresetn clears valid bits and loads register defaults
module grid_line_overlay
    import glo_pkg::*;
#(
    parameter int COORD_BITS = 14,
    parameter int COUNT_BITS = 10
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // pix_col, pix_row, in_blue, in_green, in_red, zero fill
    input  logic [((2*COORD_BITS+24+7)/8)*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_blue, out_green, out_red
    output logic [23:0] m_tdata,
    // on_grid
    output logic [0:0]  m_tuser,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [((2*COORD_BITS > COORD_BITS+COUNT_BITS) ?
                   2*COORD_BITS : COORD_BITS+COUNT_BITS)-1:0] cfg_wdata
);

    localparam int C  = COORD_BITS;
    localparam int N  = COUNT_BITS;
    localparam int XW = C + 1;
    localparam int MW = C + N;
    localparam int QW = (XW > N) ? XW : N;

    typedef struct packed {
        rgb_t          pix;
        logic          h_ok;
        logic          v_ok;
        logic [XW-1:0] hx;
        logic [XW-1:0] vx;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

    function automatic logic [2*C-1:0] span_fn(input logic [2*C-1:0] span,
                                               input logic [C-1:0]   lim);
        logic [C-1:0] a;
        logic [C-1:0] b;
        logic [C-1:0] t;
        a = span[C-1:0];
        b = span[2*C-1:C];
        if (b == '0) begin
            b = lim;
        end
        if (b < a) begin
            t = a;
            a = b;
            b = t;
        end
        if (b > lim) begin
            b = lim;
        end
        return {b, a};
    endfunction

    function automatic logic line_hit(input logic          ok,
                                      input logic [XW-1:0] x,
                                      input logic [XW-1:0] q,
                                      input logic [C-1:0]  r,
                                      input logic [C-1:0]  step,
                                      input logic [N-1:0]  count,
                                      input logic [MW-1:0] m,
                                      input logic [3:0]    spn);
        logic res;
        res = 1'b0;
        if (ok) begin
            if (step == '0) begin
                res = (x <= XW'(spn));
            end else if (QW'(q) < QW'(count)) begin
                res = (r <= C'(spn));
            end else begin
                res = ((MW+1)'(x) <= (MW+1)'(m) + (MW+1)'(spn));
            end
        end
        return res;
    endfunction

    // configuration registers
    draw_style_t    style_reg;
    logic [2*C-1:0] frame_reg;
    logic [C-1:0]   h_origin_reg;
    logic [C+N-1:0] h_grid_reg;
    logic [2*C-1:0] h_span_reg;
    logic [C-1:0]   v_origin_reg;
    logic [C+N-1:0] v_grid_reg;
    logic [2*C-1:0] v_span_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            style_reg    <= STYLE_RESET;
            frame_reg    <= '0;
            h_origin_reg <= '0;
            h_grid_reg   <= '0;
            h_span_reg   <= '0;
            v_origin_reg <= '0;
            v_grid_reg   <= '0;
            v_span_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_DRAW_STYLE: style_reg    <= draw_style_t'(cfg_wdata[STYLE_W-1:0]);
                REG_FRAME_SIZE: frame_reg    <= cfg_wdata[2*C-1:0];
                REG_H_ORIGIN:   h_origin_reg <= cfg_wdata[C-1:0];
                REG_H_GRID:     h_grid_reg   <= cfg_wdata[C+N-1:0];
                REG_H_SPAN:     h_span_reg   <= cfg_wdata[2*C-1:0];
                REG_V_ORIGIN:   v_origin_reg <= cfg_wdata[C-1:0];
                REG_V_GRID:     v_grid_reg   <= cfg_wdata[C+N-1:0];
                REG_V_SPAN:     v_span_reg   <= cfg_wdata[2*C-1:0];
                default: ;
            endcase
        end
    end

    logic [C-1:0] fw;
    logic [C-1:0] fh;
    logic [C-1:0] h_step;
    logic [C-1:0] v_step;
    logic [N-1:0] h_count;
    logic [N-1:0] v_count;
    logic [N-1:0] h_cm1;
    logic [N-1:0] v_cm1;
    logic [2:0]   half;
    logic         even;
    logic [3:0]   spn;

    assign fw      = frame_reg[C-1:0];
    assign fh      = frame_reg[2*C-1:C];
    assign h_step  = h_grid_reg[C-1:0];
    assign v_step  = v_grid_reg[C-1:0];
    assign h_count = h_grid_reg[C+N-1:C];
    assign v_count = v_grid_reg[C+N-1:C];
    assign h_cm1   = h_count - N'(1);
    assign v_cm1   = v_count - N'(1);
    assign half    = style_reg.thick[3:1];
    assign even    = ~style_reg.thick[0];
    assign spn     = style_reg.thick - 4'd1;

    // values that follow from the registers alone
    logic [2*C-1:0] hspan_reg;
    logic [2*C-1:0] vspan_reg;
    logic [MW-1:0]  hm_reg;
    logic [MW-1:0]  vm_reg;

    always_ff @(posedge aclk) begin
        hspan_reg <= span_fn(h_span_reg, fw);
        vspan_reg <= span_fn(v_span_reg, fh);
        hm_reg    <= MW'(h_cm1) * MW'(h_step);
        vm_reg    <= MW'(v_cm1) * MW'(v_step);
    end

    logic en;
    logic m_valid_reg;
    rgb_t m_data_reg;
    logic m_user_reg;

    assign en       = ~m_valid_reg | m_tready;
    assign s_tready = en;

    // stage 1: capture the pixel
    logic         s1_valid_reg;
    logic [C-1:0] s1_col_reg;
    logic [C-1:0] s1_row_reg;
    rgb_t         s1_pix_reg;
    rgb_t         in_pix;

    assign in_pix.blue  = s_tdata[2*C+7:2*C];
    assign in_pix.green = s_tdata[2*C+15:2*C+8];
    assign in_pix.red   = s_tdata[2*C+23:2*C+16];

    // stage 2: style and frame test and offsets from the clamped origins
    logic         s2_valid_reg;
    logic [C-1:0] s2_col_reg;
    logic [C-1:0] s2_row_reg;
    rgb_t         s2_pix_reg;
    logic         s2_ok_reg;
    logic [C+1:0] s2_hx_reg;
    logic [C+1:0] s2_vx_reg;

    logic         s2_ok_next;
    logic [C-1:0] h_org;
    logic [C-1:0] v_org;
    logic [C+1:0] s2_hx_next;
    logic [C+1:0] s2_vx_next;

    always_comb begin
        s2_ok_next = color_ok(style_reg.color) && (style_reg.thick != 4'd0) &&
                     (s1_col_reg < fw) && (s1_row_reg < fh);
        h_org      = (h_origin_reg > fh) ? fh : h_origin_reg;
        v_org      = (v_origin_reg > fw) ? fw : v_origin_reg;
        s2_hx_next = (C+2)'(s1_row_reg) + (C+2)'(half) - (C+2)'(h_org) - (C+2)'(even);
        s2_vx_next = (C+2)'(s1_col_reg) + (C+2)'(half) - (C+2)'(v_org) - (C+2)'(even);
    end

    // stage 3: span and enable tests
    logic  s3_valid_reg;
    side_t s3_side_reg;
    side_t s3_side_next;

    always_comb begin
        s3_side_next.pix  = s2_pix_reg;
        s3_side_next.hx   = s2_hx_reg[C:0];
        s3_side_next.vx   = s2_vx_reg[C:0];
        s3_side_next.h_ok = s2_ok_reg && style_reg.h_en && !s2_hx_reg[C+1] &&
                            (h_count != '0) &&
                            (s2_col_reg >= hspan_reg[C-1:0]) &&
                            (s2_col_reg < hspan_reg[2*C-1:C]);
        s3_side_next.v_ok = s2_ok_reg && style_reg.v_en && !s2_vx_reg[C+1] &&
                            (v_count != '0) &&
                            (s2_row_reg >= vspan_reg[C-1:0]) &&
                            (s2_row_reg < vspan_reg[2*C-1:C]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_col_reg  <= s_tdata[C-1:0];
            s1_row_reg  <= s_tdata[2*C-1:C];
            s1_pix_reg  <= in_pix;
            s2_col_reg  <= s1_col_reg;
            s2_row_reg  <= s1_row_reg;
            s2_pix_reg  <= s1_pix_reg;
            s2_ok_reg   <= s2_ok_next;
            s2_hx_reg   <= s2_hx_next;
            s2_vx_reg   <= s2_vx_next;
            s3_side_reg <= s3_side_next;
        end
    end

    // line index per direction: lane 0 horizontal, lane 1 vertical
    logic [1:0][XW-1:0] div_dvd;
    logic [1:0][C-1:0]  div_dvs;
    logic               div_valid;
    logic [1:0][XW-1:0] div_quo;
    logic [1:0][C-1:0]  div_rem;
    logic [SIDE_W-1:0]  div_side;

    assign div_dvd[0] = s3_side_reg.hx;
    assign div_dvd[1] = s3_side_reg.vx;
    assign div_dvs[0] = h_step;
    assign div_dvs[1] = v_step;

    glo_div #(
        .DVD_W  (XW),
        .DVS_W  (C),
        .SIDE_W (SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_dvd    (div_dvd),
        .dvs       (div_dvs),
        .in_side   (s3_side_reg),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_rem   (div_rem),
        .out_side  (div_side)
    );

    // final stage: line test and color select
    side_t fin_side;
    logic  h_hit;
    logic  v_hit;
    logic  hit;

    always_comb begin
        fin_side = side_t'(div_side);
        h_hit    = line_hit(fin_side.h_ok, fin_side.hx, div_quo[0], div_rem[0],
                            h_step, h_count, hm_reg, spn);
        v_hit    = line_hit(fin_side.v_ok, fin_side.vx, div_quo[1], div_rem[1],
                            v_step, v_count, vm_reg, spn);
        hit      = h_hit | v_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= hit ? color_of(style_reg.color) : fin_side.pix;
            m_user_reg <= hit;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

endmodule

// ===== hw/rtl/glo_checker.sv =====
// port-level checker for the grid line overlay, bound to the top level
`include "grid_line_overlay_macros.svh"

module glo_checker
    import glo_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    `GLO_ASSERT_RESET(a_reset_empty, !m_tvalid, "result valid right after reset")

    `GLO_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `GLO_ASSERT(a_ready_when_empty, !m_tvalid, s_tready, "input blocked with empty output")

    `GLO_ASSERT(a_grid_color, m_tvalid && m_tuser[0], (m_tdata == RGB_BLACK) || (m_tdata == RGB_WHITE) || (m_tdata == RGB_GREEN) || (m_tdata == RGB_BLUE) || (m_tdata == RGB_RED), "on-grid transaction without a grid color")

endmodule

bind grid_line_overlay glo_checker u_glo_checker (.*);
